@@ rtl/gbts_pkg.sv @@
`timescale 1ns / 1ps

package gbts_pkg;

    // fixed field widths
    localparam int FUNC_W       = 3;
    localparam int BYTE_W       = 8;
    localparam int IDX_W        = 11;
    localparam int STAT_W       = 2;
    localparam int CAPACITY_DEF = 1024;

    // operation codes
    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 3'd0,
        FN_ERASE  = 3'd1,
        FN_LEFT   = 3'd2,
        FN_RIGHT  = 3'd3,
        FN_SET    = 3'd4,
        FN_READ   = 3'd5
    } func_t;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_NONE  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_MOVE,
        S_RESULT
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic    latch_in;
        logic    do_insert;
        logic    do_erase;
        logic    do_read;
        logic    start_move;
        logic    move_step;
        logic    set_status;
        status_t status;
        logic    load_out;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        func_t func;
        logic  full;
        logic  at_start;
        logic  at_end;
        logic  idx_over_len;
        logic  idx_eq_gl;
        logic  idx_ge_len;
        logic  cnt_zero;
    } dp_flags_t;

endpackage

@@ rtl/gbts_dp.sv @@
`timescale 1ns / 1ps

module gbts_dp #(
    parameter int CAPACITY = gbts_pkg::CAPACITY_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  gbts_pkg::dp_cmd_t           cmd,
    output gbts_pkg::dp_flags_t         flags,
    input  logic [gbts_pkg::FUNC_W-1:0] func,
    input  logic [gbts_pkg::BYTE_W-1:0] ch,
    input  logic [gbts_pkg::IDX_W-1:0]  index,
    output logic [gbts_pkg::BYTE_W-1:0] out_byte,
    output logic [gbts_pkg::IDX_W-1:0]  cursor,
    output logic [gbts_pkg::IDX_W-1:0]  text_length,
    output logic [gbts_pkg::STAT_W-1:0] status
);
    import gbts_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PW = $clog2(CAPACITY + 1);
    localparam int CW = (PW > IDX_W) ? PW : IDX_W;

    // text store
    logic [BYTE_W-1:0] mem [CAPACITY];

    // control state
    logic [PW-1:0] gl_reg, gl_next;
    logic [PW-1:0] gh_reg, gh_next;
    logic          pend_reg, pend_next;

    // payload state
    func_t             func_reg;
    logic [BYTE_W-1:0] ch_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [PW-1:0]     src_reg, dst_reg, cnt_reg;
    logic              fwd_reg;
    logic [BYTE_W-1:0] rd_data_reg;
    status_t           status_reg;
    logic              use_mem_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [IDX_W-1:0]  cursor_reg;
    logic [IDX_W-1:0]  length_reg;
    status_t           out_status_reg;

    logic [PW-1:0]     gap_w, len, gl_dec, target;
    logic [CW-1:0]     idx_c, len_c, gl_c, rd_pos;
    logic              fwd;
    logic              wr_en, rd_en;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [BYTE_W-1:0] wr_data;

    // gap geometry and compares
    always_comb
    begin
        gap_w  = gh_reg - gl_reg;
        len    = PW'(CAPACITY) - gap_w;
        gl_dec = gl_reg - PW'(1);
        idx_c  = CW'(idx_reg);
        len_c  = CW'(len);
        gl_c   = CW'(gl_reg);
        rd_pos = (idx_c < gl_c) ? idx_c : idx_c + CW'(gap_w);
    end

    // new cursor for moves
    always_comb
    begin
        case (func_reg)
            FN_LEFT:  target = gl_dec;
            FN_RIGHT: target = gl_reg + PW'(1);
            default:  target = PW'(idx_reg);
        endcase
        fwd = (target > gl_reg);
    end

    // status to controller
    always_comb
    begin
        flags.func         = func_reg;
        flags.full         = (gl_reg == gh_reg);
        flags.at_start     = (gl_reg == '0);
        flags.at_end       = (gh_reg == PW'(CAPACITY));
        flags.idx_over_len = (idx_c > len_c);
        flags.idx_eq_gl    = (idx_c == gl_c);
        flags.idx_ge_len   = (idx_c >= len_c);
        flags.cnt_zero     = (cnt_reg == '0);
    end

    // memory port control
    always_comb
    begin
        wr_en   = cmd.do_insert | (cmd.move_step & pend_reg);
        wr_addr = cmd.do_insert ? gl_reg[AW-1:0] : dst_reg[AW-1:0];
        wr_data = cmd.do_insert ? ch_reg : rd_data_reg;
        rd_en   = cmd.do_erase | cmd.do_read | (cmd.move_step & ~flags.cnt_zero);
        if (cmd.do_erase)
        begin
            rd_addr = gl_dec[AW-1:0];
        end
        else if (cmd.do_read)
        begin
            rd_addr = rd_pos[AW-1:0];
        end
        else
        begin
            rd_addr = src_reg[AW-1:0];
        end
    end

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // gap pointer update
    always_comb
    begin
        gl_next   = gl_reg;
        gh_next   = gh_reg;
        pend_next = pend_reg;
        if (cmd.do_insert)
        begin
            gl_next = gl_reg + PW'(1);
        end
        else if (cmd.do_erase)
        begin
            gl_next = gl_dec;
        end
        else if (cmd.start_move)
        begin
            gl_next   = target;
            gh_next   = target + gap_w;
            pend_next = 1'b0;
        end
        else if (cmd.move_step)
        begin
            pend_next = ~flags.cnt_zero;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gl_reg   <= '0;
            gh_reg   <= PW'(CAPACITY);
            pend_reg <= 1'b0;
        end
        else
        begin
            gl_reg   <= gl_next;
            gh_reg   <= gh_next;
            pend_reg <= pend_next;
        end
    end

    // input latch, copy pointers, result registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            func_reg <= func_t'(func);
            ch_reg   <= ch;
            idx_reg  <= index;
        end
        if (cmd.start_move)
        begin
            fwd_reg <= fwd;
            src_reg <= fwd ? gh_reg : gl_dec;
            dst_reg <= fwd ? gl_reg : gh_reg - PW'(1);
            cnt_reg <= fwd ? target - gl_reg : gl_reg - target;
        end
        else if (cmd.move_step)
        begin
            if (!flags.cnt_zero)
            begin
                src_reg <= fwd_reg ? src_reg + PW'(1) : src_reg - PW'(1);
                cnt_reg <= cnt_reg - PW'(1);
            end
            if (pend_reg)
            begin
                dst_reg <= fwd_reg ? dst_reg + PW'(1) : dst_reg - PW'(1);
            end
        end
        if (cmd.set_status)
        begin
            status_reg  <= cmd.status;
            use_mem_reg <= cmd.do_erase | cmd.do_read;
        end
        if (cmd.load_out)
        begin
            out_byte_reg   <= use_mem_reg ? rd_data_reg : '0;
            cursor_reg     <= IDX_W'(gl_reg);
            length_reg     <= IDX_W'(len);
            out_status_reg <= status_reg;
        end
    end

    assign out_byte    = out_byte_reg;
    assign cursor      = cursor_reg;
    assign text_length = length_reg;
    assign status      = out_status_reg;

`ifndef SYNTHESIS
    // gap never inverts
    a_gap_order: assert property (@(posedge clk) disable iff (!rst_n)
        gl_reg <= gh_reg)
        else $error("gap low passed gap high");

    // a cursor jump keeps the gap width
    a_move_width: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_move |=> (gh_reg - gl_reg) == $past(gh_reg - gl_reg))
        else $error("cursor jump changed gap width");

    // insert advances the cursor by one and keeps the gap end
    a_insert_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_insert |=> (gl_reg == $past(gl_reg) + PW'(1)) && $stable(gh_reg))
        else $error("insert did not advance cursor");
`endif

endmodule

@@ rtl/gbts_ctrl.sv @@
`timescale 1ns / 1ps

module gbts_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  gbts_pkg::dp_flags_t flags,
    output gbts_pkg::dp_cmd_t   cmd
);
    import gbts_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;
    logic   accept;

    assign slot_free = ~out_valid_reg | ~out_stall;
    assign accept    = in_valid & ~in_stall;

    // command and handshake outputs
    always_comb
    begin
        cmd            = '0;
        cmd.status     = ST_NONE;
        in_stall       = 1'b1;
        out_valid_next = out_valid_reg & out_stall;
        case (state_reg)
            S_IDLE:
            begin
                in_stall     = 1'b0;
                cmd.latch_in = in_valid;
            end
            S_DECODE:
            begin
                cmd.set_status = 1'b1;
                case (flags.func)
                    FN_INSERT:
                    begin
                        if (flags.full)
                        begin
                            cmd.status = ST_FULL;
                        end
                        else
                        begin
                            cmd.do_insert = 1'b1;
                            cmd.status    = ST_DONE;
                        end
                    end
                    FN_ERASE:
                    begin
                        if (!flags.at_start)
                        begin
                            cmd.do_erase = 1'b1;
                            cmd.status   = ST_DONE;
                        end
                    end
                    FN_LEFT:
                    begin
                        if (!flags.at_start)
                        begin
                            cmd.start_move = 1'b1;
                            cmd.status     = ST_DONE;
                        end
                    end
                    FN_RIGHT:
                    begin
                        if (!flags.at_end)
                        begin
                            cmd.start_move = 1'b1;
                            cmd.status     = ST_DONE;
                        end
                    end
                    FN_SET:
                    begin
                        if (flags.idx_over_len)
                        begin
                            cmd.status = ST_RANGE;
                        end
                        else if (!flags.idx_eq_gl)
                        begin
                            cmd.start_move = 1'b1;
                            cmd.status     = ST_DONE;
                        end
                    end
                    FN_READ:
                    begin
                        if (flags.idx_ge_len)
                        begin
                            cmd.status = ST_RANGE;
                        end
                        else
                        begin
                            cmd.do_read = 1'b1;
                            cmd.status  = ST_DONE;
                        end
                    end
                    default:
                    begin
                        cmd.status = ST_NONE;
                    end
                endcase
            end
            S_MOVE:
            begin
                cmd.move_step = 1'b1;
            end
            S_RESULT:
            begin
                if (slot_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    in_stall       = 1'b0;
                    cmd.latch_in   = in_valid;
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = cmd.start_move ? S_MOVE : S_RESULT;
            end
            S_MOVE:
            begin
                if (flags.cnt_zero)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (slot_free)
                begin
                    state_next = accept ? S_DECODE : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    // an accepted transfer is always decoded next
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_DECODE)
        else $error("accepted transfer not decoded");

    // a result never overwrites one still waiting downstream
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> slot_free)
        else $error("result register overwritten");

    // every result load raises output valid
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid)
        else $error("loaded result not presented");
`endif

endmodule

@@ rtl/gap_buffer_text_store.sv @@
`timescale 1ns / 1ps
// Gap buffer text store: a fixed store of CAPACITY bytes with the cursor at the gap.
// Input channel (in_valid / in_stall) carries func, ch and index; an operation is
// taken when in_valid is high and in_stall low. Output channel (out_valid /
// out_stall) returns one transfer per operation: out_byte, cursor, text_length,
// status. Operations complete strictly in order, one at a time.
// Insert, erase, read and every refused or empty operation go from the decode
// state straight to the result state; a cursor left/right or jump first passes
// through the move state. The copy moves one byte per cycle through the single
// read port and single write port of the store, which sets the jump time. The
// next operation is accepted in the same cycle its predecessor's result is
// loaded into the output register.
// While the receiver stalls, the result register holds; the block still takes
// and finishes one more operation, then stalls its input until the result leaves.
// Reset empties the text (cursor and length zero); store contents are left
// undefined and no clearing pass runs, so the block is ready right after reset.
module gap_buffer_text_store #(
    parameter int CAPACITY = gbts_pkg::CAPACITY_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [gbts_pkg::FUNC_W-1:0] func,
    input  logic [gbts_pkg::BYTE_W-1:0] ch,
    input  logic [gbts_pkg::IDX_W-1:0]  index,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [gbts_pkg::BYTE_W-1:0] out_byte,
    output logic [gbts_pkg::IDX_W-1:0]  cursor,
    output logic [gbts_pkg::IDX_W-1:0]  text_length,
    output logic [gbts_pkg::STAT_W-1:0] status
);
    import gbts_pkg::*;

    dp_cmd_t   cmd;
    dp_flags_t flags;

    // sequencing and handshakes
    gbts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .flags     (flags),
        .cmd       (cmd)
    );

    // store, gap pointers and result register
    gbts_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .flags       (flags),
        .func        (func),
        .ch          (ch),
        .index       (index),
        .out_byte    (out_byte),
        .cursor      (cursor),
        .text_length (text_length),
        .status      (status)
    );

endmodule
